// ----- rtl/core/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg: shared definitions for the first-fit slot allocator
// Command and status codes, controller states, and the control word that
// links the controller to the datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Default number of slots in the store.
  localparam int SLOTS_DEFAULT = 256;

  // Free marks are searched in groups of this many bits.
  localparam int GROUP_W = 16;

  // Configuration port widths.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes (the upper address bit selects the register).
  localparam logic REG_NODE_ID = 1'b0;

  // Command codes carried by an input word.
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  // Status codes carried by a result word.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FULL         = 3'd1;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd2;
  localparam logic [2:0] ST_BEYOND       = 3'd3;
  localparam logic [2:0] ST_MISMATCH     = 3'd4;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and start the memory read
    logic execute;  // update the store and load the result register
  } ctl_t;

endpackage

// ----- rtl/core/ffsa_cfg.sv -----
// ----------------------------------------------------------------------------
// ffsa_cfg: configuration registers
// APB-style register file holding the node id returned with allocations.
// ----------------------------------------------------------------------------
module ffsa_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffsa_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffsa_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffsa_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [15:0]                     node_id
);

  logic write_en;
  logic sel_node;

  // The upper address bit picks the register; low bits are byte offsets.
  assign sel_node = (paddr[ffsa_pkg::PADDR_W-1] == ffsa_pkg::REG_NODE_ID);
  assign write_en = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Node id register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= '0;
    end else if (write_en && sel_node) begin
      node_id <= pwdata[15:0];
    end
  end

  // Read data; addresses past the register list read as zero.
  always_comb begin
    prdata = '0;
    if (sel_node) begin
      prdata = {{(ffsa_pkg::PDATA_W-16){1'b0}}, node_id};
    end
  end

endmodule

// ----- rtl/core/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffsa_ctrl: sequencing controller
// Two-state machine that takes one word, runs it through the datapath, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ffsa_pkg::ctl_t ctl
);

  ffsa_pkg::state_t state;
  ffsa_pkg::state_t state_next;
  logic             accept;

  // A word is taken only when the result register is empty or draining.
  assign in_ready = (state == ffsa_pkg::S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffsa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ffsa_pkg::S_EXEC) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ffsa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ffsa_pkg::S_EXEC;
        end
      end
      ffsa_pkg::S_EXEC: begin
        state_next = ffsa_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    unique case (state)
      ffsa_pkg::S_IDLE: begin
        ctl.capture = accept;
      end
      ffsa_pkg::S_EXEC: begin
        ctl.execute = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/ffsa_datapath.sv -----
// ----------------------------------------------------------------------------
// ffsa_datapath: slot store, free map and result register
// Holds the owner/value memory, the free marks with a two-level first-free
// encoder, the high-water mark and the occupancy count.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
  parameter int SLOTS = ffsa_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ffsa_pkg::ctl_t     ctl,
  input  logic [15:0]        node_id,
  input  logic [1:0]         command,
  input  logic [15:0]        owner_id,
  input  logic signed [31:0] data_value,
  input  logic [7:0]         slot_index,
  output logic [2:0]         status,
  output logic [15:0]        node_tag,
  output logic [7:0]         slot_out,
  output logic [8:0]         used_count
);

  localparam int GW   = ffsa_pkg::GROUP_W;
  localparam int BIW  = $clog2(GW);
  localparam int NG   = (SLOTS + GW - 1) / GW;
  localparam int NP   = NG * GW;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW   = GIW + BIW;
  localparam int IW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;
  localparam int MW   = 16 + 32;

  // Captured input word.
  ffsa_pkg::cmd_t cmd_q;
  logic [15:0]    owner_q;
  logic [31:0]    data_q;
  logic [7:0]     idx_q;

  // Store: owner in the upper half, value in the lower half.
  logic [MW-1:0]  mem [SLOTS];
  logic [MW-1:0]  rdata;

  // Free marks (padding bits stay clear) and per-group summaries.
  logic [NP-1:0]  free_bits;
  logic [NG-1:0]  grp_any;
  logic [NG-1:0]  grp_any_next;

  logic [CW-1:0]  high_water;
  logic [CW-1:0]  occupied;

  // Encoder and decision signals.
  logic [GIW-1:0] gidx;
  logic [BIW-1:0] bidx;
  logic [GW-1:0]  grp_word;
  logic [PW-1:0]  first_free;
  logic [IW-1:0]  alloc_slot;
  logic           found;
  logic           beyond;
  logic [IW-1:0]  idx_addr;
  logic [IW:0]    alloc_end;
  logic           owner_match;

  // Next contents of the result register.
  logic [2:0]     status_next;
  logic [15:0]    node_tag_next;
  logic [7:0]     slot_out_next;

  // Reset pattern for the free marks: one bit for each real slot.
  function automatic logic [NP-1:0] free_init();
    logic [NP-1:0] v;
    v = '0;
    for (int i = 0; i < SLOTS; i++) begin
      v[i] = 1'b1;
    end
    return v;
  endfunction

  // Group summaries are registered before they feed the encoder.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_next[g] = |free_bits[g*GW +: GW];
    end
  end

  // Lowest group with a free slot, then the lowest free bit inside it.
  always_comb begin
    gidx = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gidx = GIW'(g);
      end
    end
    grp_word = free_bits[gidx*GW +: GW];
    bidx = '0;
    for (int b = GW - 1; b >= 0; b--) begin
      if (grp_word[b]) begin
        bidx = BIW'(b);
      end
    end
  end

  assign found       = |grp_any;
  assign first_free  = {gidx, bidx};
  assign alloc_slot  = first_free[IW-1:0];
  assign alloc_end   = {1'b0, alloc_slot} + (IW+1)'(1);
  assign idx_addr    = IW'(idx_q);
  assign beyond      = CMPW'(idx_q) >= CMPW'(high_water);
  assign owner_match = (rdata[MW-1:32] == owner_q);

  // Input capture and memory read at the addressed slot.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= ffsa_pkg::cmd_t'(command);
      owner_q <= owner_id;
      data_q  <= data_value;
      idx_q   <= slot_index;
      rdata   <= mem[IW'(slot_index)];
    end
  end

  // Memory writes on a successful allocate or modify.
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      if (cmd_q == ffsa_pkg::CMD_ALLOC && found) begin
        mem[alloc_slot] <= {owner_q, data_q};
      end else if (cmd_q == ffsa_pkg::CMD_MODIFY && !beyond && owner_match) begin
        mem[idx_addr] <= {owner_q, data_q};
      end
    end
  end

  // Free marks, high-water mark and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_bits  <= free_init();
      grp_any    <= '0;
      high_water <= '0;
      occupied   <= '0;
    end else begin
      grp_any <= grp_any_next;
      if (ctl.execute) begin
        if (cmd_q == ffsa_pkg::CMD_ALLOC && found) begin
          free_bits[alloc_slot] <= 1'b0;
          occupied <= occupied + CW'(1);
          if (alloc_end > (IW+1)'(high_water)) begin
            high_water <= CW'(alloc_end);
          end
        end else if (cmd_q == ffsa_pkg::CMD_FREE && !beyond && !free_bits[idx_addr]) begin
          free_bits[idx_addr] <= 1'b1;
          occupied <= occupied - CW'(1);
        end
      end
    end
  end

  // Result contents for the word being completed.
  always_comb begin
    status_next   = ffsa_pkg::ST_OK;
    node_tag_next = '0;
    slot_out_next = 8'(idx_q);
    if (ctl.execute) begin
      unique case (cmd_q)
        ffsa_pkg::CMD_ALLOC: begin
          node_tag_next = node_id;
          if (found) begin
            slot_out_next = 8'(alloc_slot);
          end else begin
            status_next   = ffsa_pkg::ST_FULL;
            slot_out_next = '0;
          end
        end
        ffsa_pkg::CMD_FREE: begin
          if (beyond) begin
            status_next = ffsa_pkg::ST_BEYOND;
          end else if (free_bits[idx_addr]) begin
            status_next = ffsa_pkg::ST_ALREADY_FREE;
          end
        end
        ffsa_pkg::CMD_MODIFY: begin
          if (beyond) begin
            status_next = ffsa_pkg::ST_BEYOND;
          end else if (!owner_match) begin
            status_next = ffsa_pkg::ST_MISMATCH;
          end
        end
        ffsa_pkg::CMD_QUERY: begin
          slot_out_next = '0;
        end
      endcase
    end
  end

  // Result register, loaded as the word completes.
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status   <= status_next;
      node_tag <= node_tag_next;
      slot_out <= slot_out_next;
    end
  end

  // The count is shown after this word's update.
  assign used_count = 9'(occupied);

endmodule

// ----- rtl/core/first_fit_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator: first-fit allocator over a fixed slot store
// Allocates the lowest free slot, frees and modifies slots, reports usage.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one word: command, owner_id,
//   data_value and slot_index. Each word gives exactly one result word on the
//   output channel (out_valid/out_ready): status, node_tag, slot_out and
//   used_count.
//   Each word is first captured while the slot memory is read, then the
//   store is updated and the result register loaded. A new word is not
//   taken until the last one has loaded the result register. The memory
//   read ahead of the read-modify-write, and the registered group summary of
//   the free marks feeding the first-free encoder, are why words do not overlap.
//   When the receiver stalls, the result is held and in_ready stays low until
//   the result register drains or drains in the same cycle.
//   Reset marks every slot free and clears the high-water mark, the usage
//   count and node_id; no clearing pass is needed. The user must write node_id
//   over the APB-style port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator #(
  parameter int SLOTS = ffsa_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [ffsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [ffsa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [15:0]                   owner_id,
  input  logic signed [31:0]            data_value,
  input  logic [7:0]                    slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [15:0]                   node_tag,
  output logic [7:0]                    slot_out,
  output logic [8:0]                    used_count
);

  ffsa_pkg::ctl_t ctl;
  logic [15:0]    node_id;

  // Configuration registers.
  ffsa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .node_id (node_id)
  );

  // Sequencing controller.
  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Store and result datapath.
  ffsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .node_id    (node_id),
    .command    (command),
    .owner_id   (owner_id),
    .data_value (data_value),
    .slot_index (slot_index),
    .status     (status),
    .node_tag   (node_tag),
    .slot_out   (slot_out),
    .used_count (used_count)
  );

endmodule

// ----- rtl/core/ffsa_checker.sv -----
// ----------------------------------------------------------------------------
// ffsa_checker: port-level assertions for the slot allocator
// Checks sequencing, latency and result consistency seen at the ports.
// ----------------------------------------------------------------------------
module ffsa_checker #(
  parameter int SLOTS = ffsa_pkg::SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] node_tag,
  input logic [7:0]  slot_out,
  input logic [8:0]  used_count
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_out)
      && $stable(node_tag) && $stable(used_count))
    else $error("result word changed while stalled");

  // Only one word is in flight: no acceptance right after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // The result appears after the accepted word has been captured and executed.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result not presented two cycles after acceptance");

  // A full store reports every slot in use.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ffsa_pkg::ST_FULL) |-> (used_count == 9'(SLOTS)))
    else $error("store reported full with free slots left");

endmodule

bind first_fit_slot_allocator ffsa_checker #(.SLOTS(SLOTS)) u_ffsa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .node_tag   (node_tag),
  .slot_out   (slot_out),
  .used_count (used_count)
);
